// ----- src/csf_pkg.sv -----
package csf_pkg;

  localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
  localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
  localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;

  localparam int unsigned MIX_SHIFT_A = 30;
  localparam int unsigned MIX_SHIFT_B = 27;
  localparam int unsigned MIX_SHIFT_C = 31;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BODY_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAF_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE_MASK = 2'd2;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] acc;
    logic [63:0] v;
  } fold_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fold_rsp_t;

endpackage

// ----- src/csf_mul.sv -----
module csf_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csf_pkg::mul_req_t req_i,
  output csf_pkg::mul_rsp_t rsp_o
);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_LL   = 3'd1;
  localparam logic [2:0] M_LH   = 3'd2;
  localparam logic [2:0] M_HL   = 3'd3;
  localparam logic [2:0] M_SUM  = 3'd4;

  logic [2:0]  state_q;
  logic        done_q;
  logic [63:0] a_q, b_q;
  logic [63:0] acc_q;
  logic [63:0] prod_q;
  logic [31:0] op_x, op_y;
  logic [63:0] prod;

  // one 32x32 multiplier, low 64 bits built from three partial products
  always_comb begin
    unique case (state_q)
      M_LH: begin
        op_x = a_q[31:0];
        op_y = b_q[63:32];
      end
      M_HL: begin
        op_x = a_q[63:32];
        op_y = b_q[31:0];
      end
      default: begin
        op_x = a_q[31:0];
        op_y = b_q[31:0];
      end
    endcase
  end

  assign prod = {32'd0, op_x} * {32'd0, op_y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        M_IDLE: begin
          if (req_i.start) begin
            state_q <= M_LL;
          end
        end
        M_LL:  state_q <= M_LH;
        M_LH:  state_q <= M_HL;
        M_HL:  state_q <= M_SUM;
        M_SUM: begin
          state_q <= M_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          a_q <= req_i.a;
          b_q <= req_i.b;
        end
      end
      M_LL: prod_q <= prod;
      M_LH: begin
        acc_q  <= prod_q;
        prod_q <= prod;
      end
      M_HL: begin
        acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
        prod_q       <= prod;
      end
      M_SUM: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule

// ----- src/csf_fold.sv -----
module csf_fold (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csf_pkg::fold_req_t req_i,
  output csf_pkg::fold_rsp_t rsp_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_M1   = 2'd1;
  localparam logic [1:0] F_M2   = 2'd2;
  localparam logic [1:0] F_M3   = 2'd3;

  logic [1:0]        state_q;
  logic              done_q;
  logic [63:0]       acc_q;
  logic [63:0]       res_q;
  csf_pkg::mul_req_t mreq;
  csf_pkg::mul_rsp_t mrsp;

  csf_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mreq),
    .rsp_o (mrsp)
  );

  // splitmix64 finalizer, then xor into acc and multiply by the prime
  always_comb begin
    unique case (state_q)
      F_IDLE: begin
        mreq.start = req_i.start;
        mreq.a     = req_i.v ^ (req_i.v >> csf_pkg::MIX_SHIFT_A);
        mreq.b     = csf_pkg::MIX_MUL_A;
      end
      F_M1: begin
        mreq.start = mrsp.done;
        mreq.a     = mrsp.p ^ (mrsp.p >> csf_pkg::MIX_SHIFT_B);
        mreq.b     = csf_pkg::MIX_MUL_B;
      end
      F_M2: begin
        mreq.start = mrsp.done;
        mreq.a     = acc_q ^ (mrsp.p ^ (mrsp.p >> csf_pkg::MIX_SHIFT_C));
        mreq.b     = csf_pkg::FNV_PRIME;
      end
      default: begin
        mreq.start = 1'b0;
        mreq.a     = mrsp.p;
        mreq.b     = csf_pkg::FNV_PRIME;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        F_IDLE: begin
          if (req_i.start) begin
            state_q <= F_M1;
          end
        end
        F_M1: begin
          if (mrsp.done) begin
            state_q <= F_M2;
          end
        end
        F_M2: begin
          if (mrsp.done) begin
            state_q <= F_M3;
          end
        end
        F_M3: begin
          if (mrsp.done) begin
            state_q <= F_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && req_i.start) begin
      acc_q <= req_i.acc;
    end
    if (state_q == F_M3 && mrsp.done) begin
      res_q <= mrsp.p;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

// ----- src/csf_div.sv -----
module csf_div #(
  parameter int DW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [31:0]   quot_o,
  output logic [DW-1:0] rem_o
);

  logic          busy_q;
  logic          done_q;
  logic [4:0]    cnt_q;
  logic [31:0]   quot_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quot_q[31]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[30:0], ge};
      rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ----- src/chunked_stream_fingerprint.sv -----
// each data word takes one fold: three 64-bit multiplies, built from partial products
//   on one 32x32 multiplier
// first word of a catalog adds four header folds and a divide, a chunk end adds a total
//   fold and, unless it is the last chunk, a seed fold for the next chunk
// throughput: one word in flight at a time, in_stall_o is high until it is done
// reset: async active low, registers return to body count 1, leaf size 1, mask off
module chunked_stream_fingerprint #(
  parameter int HASH_CHUNKS = 64,
  parameter int COORDS      = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [csf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [csf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [63:0]                    data_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [63:0]                    fingerprint_o
);

  localparam int CW = $clog2(HASH_CHUNKS + 1);
  localparam logic [3:0] WPB_BASE = 4'(COORDS + 3);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_H_N    = 4'd1;
  localparam logic [3:0] S_H_LC   = 4'd2;
  localparam logic [3:0] S_H_MSK  = 4'd3;
  localparam logic [3:0] S_H_SEED = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_WORD   = 4'd6;
  localparam logic [3:0] S_TOTAL  = 4'd7;
  localparam logic [3:0] S_SEED   = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0]  state_q;
  logic        pend_q;
  logic        header_done_q;
  logic [31:0] body_count_q;
  logic [30:0] leaf_cap_q;
  logic        mask_q;
  logic [63:0] word_q;
  logic [63:0] total_q;
  logic [63:0] chunk_q;
  logic [CW-1:0] chunk_num_q;
  logic [31:0] bodies_q;
  logic [2:0]  word_idx_q;
  logic [31:0] base_q;
  logic [CW-1:0] extra_q;
  logic        out_valid_q;
  logic [63:0] out_q;

  logic [31:0]   n_eff;
  logic [CW-1:0] chunks;
  logic [3:0]    wpb;
  logic [3:0]    word_next;
  logic [32:0]   bodies_next;
  logic [32:0]   chunk_size;
  logic [CW-1:0] chunk_num_next;
  logic          fold_state;
  logic          in_acc;
  logic          out_load;
  logic          cfg_hit;

  csf_pkg::fold_req_t freq;
  csf_pkg::fold_rsp_t frsp;
  logic               div_start;
  logic               div_done;
  logic [31:0]        div_quot;
  logic [CW-1:0]      div_rem;

  assign n_eff  = (body_count_q == 32'd0) ? 32'd1 : body_count_q;
  assign chunks = (n_eff < 32'(HASH_CHUNKS)) ? n_eff[CW-1:0] : CW'(HASH_CHUNKS);
  assign wpb    = WPB_BASE + {3'd0, mask_q};

  assign word_next      = {1'b0, word_idx_q} + 4'd1;
  assign bodies_next    = {1'b0, bodies_q} + 33'd1;
  assign chunk_size     = {1'b0, base_q} + {32'd0, (chunk_num_q < extra_q)};
  assign chunk_num_next = chunk_num_q + CW'(1);

  assign fold_state = (state_q == S_H_N) || (state_q == S_H_LC) || (state_q == S_H_MSK) ||
                      (state_q == S_H_SEED) || (state_q == S_WORD) ||
                      (state_q == S_TOTAL) || (state_q == S_SEED);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);
  assign cfg_hit    = cfg_we_i && ((cfg_idx_i == csf_pkg::CFG_BODY_COUNT) ||
                                   (cfg_idx_i == csf_pkg::CFG_LEAF_SIZE) ||
                                   (cfg_idx_i == csf_pkg::CFG_INCLUDE_MASK));

  assign div_start  = (state_q == S_DIV) && !pend_q;

  always_comb begin
    freq.start = fold_state && !pend_q;
    unique case (state_q)
      S_H_N: begin
        freq.acc = csf_pkg::FNV_BASIS;
        freq.v   = {32'd0, n_eff};
      end
      S_H_LC: begin
        freq.acc = total_q;
        freq.v   = {33'd0, leaf_cap_q};
      end
      S_H_MSK: begin
        freq.acc = total_q;
        freq.v   = {63'd0, mask_q};
      end
      S_WORD: begin
        freq.acc = chunk_q;
        freq.v   = word_q;
      end
      S_TOTAL: begin
        freq.acc = total_q;
        freq.v   = chunk_q;
      end
      S_SEED: begin
        freq.acc = csf_pkg::FNV_BASIS;
        freq.v   = {{(64 - CW){1'b0}}, chunk_num_q};
      end
      default: begin
        freq.acc = csf_pkg::FNV_BASIS;
        freq.v   = '0;
      end
    endcase
  end

  csf_fold u_fold (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (freq),
    .rsp_o (frsp)
  );

  csf_div #(
    .DW(CW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (n_eff),
    .den_i  (chunks),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  // sequencer and stream control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      pend_q        <= 1'b0;
      header_done_q <= 1'b0;
      body_count_q  <= 32'd1;
      leaf_cap_q    <= 31'd1;
      mask_q        <= 1'b0;
      chunk_num_q   <= '0;
      bodies_q      <= '0;
      word_idx_q    <= '0;
      base_q        <= '0;
      extra_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          csf_pkg::CFG_BODY_COUNT:   body_count_q <= cfg_wdata_i;
          csf_pkg::CFG_LEAF_SIZE:    leaf_cap_q   <= cfg_wdata_i[30:0];
          csf_pkg::CFG_INCLUDE_MASK: mask_q       <= cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (freq.start || div_start) begin
        pend_q <= 1'b1;
      end else if (frsp.done || div_done) begin
        pend_q <= 1'b0;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= header_done_q ? S_WORD : S_H_N;
          end
        end
        S_H_N: begin
          if (frsp.done) begin
            state_q <= S_H_LC;
          end
        end
        S_H_LC: begin
          if (frsp.done) begin
            state_q <= S_H_MSK;
          end
        end
        S_H_MSK: begin
          if (frsp.done) begin
            state_q <= S_H_SEED;
          end
        end
        S_H_SEED: begin
          if (frsp.done) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            base_q        <= div_quot;
            extra_q       <= div_rem;
            chunk_num_q   <= '0;
            bodies_q      <= '0;
            word_idx_q    <= '0;
            header_done_q <= 1'b1;
            state_q       <= S_WORD;
          end
        end
        S_WORD: begin
          if (frsp.done) begin
            if (word_next < wpb) begin
              word_idx_q <= word_next[2:0];
              state_q    <= S_IDLE;
            end else begin
              word_idx_q <= '0;
              if (bodies_next < chunk_size) begin
                bodies_q <= bodies_next[31:0];
                state_q  <= S_IDLE;
              end else begin
                bodies_q <= '0;
                state_q  <= S_TOTAL;
              end
            end
          end
        end
        S_TOTAL: begin
          if (frsp.done) begin
            chunk_num_q <= chunk_num_next;
            state_q     <= (chunk_num_next >= chunks) ? S_EMIT : S_SEED;
          end
        end
        S_SEED: begin
          if (frsp.done) begin
            state_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            header_done_q <= 1'b0;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (cfg_hit) begin
        header_done_q <= 1'b0;
      end
    end
  end

  // hash datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      word_q <= data_word_i;
    end
    if (frsp.done) begin
      if ((state_q == S_H_N) || (state_q == S_H_LC) || (state_q == S_H_MSK) ||
          (state_q == S_TOTAL)) begin
        total_q <= frsp.res;
      end else begin
        chunk_q <= frsp.res;
      end
    end
    if (out_load) begin
      out_q <= total_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign fingerprint_o = out_q;

endmodule
